/* rtl/key_to_pointer_translator_assert.svh */
// assertion helpers for the rtl files, included by kpt_rsp_queue
`ifndef KEY_TO_POINTER_TRANSLATOR_ASSERT_SVH
`define KEY_TO_POINTER_TRANSLATOR_ASSERT_SVH

// same-cycle implication, checked on clock, quiet during reset
`define KPT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kpt assertion failed");

// next-cycle implication
`define KPT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kpt assertion failed");

`endif

/* rtl/kpt_pkg.sv */
package kpt_pkg;

   // virtual key codes
   localparam logic [7:0] KEY_LALT = 8'hA4;
   localparam logic [7:0] KEY_W    = 8'h57;
   localparam logic [7:0] KEY_A    = 8'h41;
   localparam logic [7:0] KEY_S    = 8'h53;
   localparam logic [7:0] KEY_D    = 8'h44;
   localparam logic [7:0] KEY_Q    = 8'h51;
   localparam logic [7:0] KEY_E    = 8'h45;

   // bit positions in the held key flags
   localparam int HK_W = 0;
   localparam int HK_A = 1;
   localparam int HK_S = 2;
   localparam int HK_D = 3;
   localparam int HK_Q = 4;
   localparam int HK_E = 5;

   // result codes
   localparam logic [2:0] RES_KEY   = 3'd0;
   localparam logic [2:0] RES_MOVE  = 3'd1;
   localparam logic [2:0] RES_LDOWN = 3'd2;
   localparam logic [2:0] RES_LUP   = 3'd3;
   localparam logic [2:0] RES_RDOWN = 3'd4;
   localparam logic [2:0] RES_RUP   = 3'd5;

   // input item kinds
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // register indexes
   localparam logic CSR_MOVE_STEP  = 1'b0;
   localparam logic CSR_TAP_WINDOW = 1'b1;

   localparam logic [6:0]  MOVE_STEP_RST  = 7'd5;
   localparam logic [15:0] TAP_WINDOW_RST = 16'd300;

   localparam int RSP_SLOTS = 3;

   typedef struct packed {
      logic        kind;
      logic [7:0]  key_code;
      logic        key_down;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]        event_res;
      logic              consumed;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic              mode_on;
      logic              last;
   } rsp_type;

   // one-hot flag for a mapped key, zero for any other code
   function automatic logic [5:0] key_mask(input logic [7:0] code);
      logic [5:0] mask;
      mask = '0;
      case (code)
         KEY_W: mask[HK_W] = 1'b1;
         KEY_A: mask[HK_A] = 1'b1;
         KEY_S: mask[HK_S] = 1'b1;
         KEY_D: mask[HK_D] = 1'b1;
         KEY_Q: mask[HK_Q] = 1'b1;
         KEY_E: mask[HK_E] = 1'b1;
         default: mask = '0;
      endcase
      return mask;
   endfunction

endpackage

/* rtl/kpt_engine.sv */
module kpt_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire_i,
   input  kpt_pkg::req_type              item_i,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [15:0]                   csr_wdata,
   output kpt_pkg::rsp_type [2:0]        res_o,
   output logic [1:0]                    count_o
);
   import kpt_pkg::*;

   logic [6:0]  move_step_ff;
   logic [15:0] tap_window_ff;

   logic [5:0]  held_keys_ff, held_keys_in;
   logic        alt_held_ff, alt_held_in;
   logic [31:0] last_alt_time_ff, last_alt_time_in;
   logic        alt_seen_ff, alt_seen_in;
   logic        active_mode_ff, active_mode_in;
   logic        left_held_ff, left_held_in;
   logic        right_held_ff, right_held_in;

   logic        is_key;
   logic        is_alt;
   logic        alt_press;
   logic [31:0] gap;
   logic        toggle;
   logic        mode_key;
   logic [5:0]  mask;
   logic        mapped;

   logic signed [7:0] step;
   logic signed [7:0] dx;
   logic signed [7:0] dy;
   logic        mv;
   logic        lv;
   logic        rv;
   logic [1:0]  count;

   rsp_type     key_r;
   rsp_type     move_r;
   rsp_type     left_r;
   rsp_type     right_r;
   rsp_type [2:0] res;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_step_ff  <= MOVE_STEP_RST;
         tap_window_ff <= TAP_WINDOW_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MOVE_STEP:  move_step_ff  <= csr_wdata[6:0];
            CSR_TAP_WINDOW: tap_window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // key event decode
   always_comb begin
      is_key    = (item_i.kind == KIND_KEY);
      is_alt    = (item_i.key_code == KEY_LALT);
      alt_press = is_key && is_alt && item_i.key_down && !alt_held_ff;
      // wrapping difference, a timestamp that runs backwards gives a huge gap
      gap       = item_i.time_ms - last_alt_time_ff;
      toggle    = alt_press && alt_seen_ff && (gap <= {16'd0, tap_window_ff});
      mode_key  = active_mode_ff ^ toggle;
      mask      = key_mask(item_i.key_code);
      mapped    = |mask;
   end

   // poll tick decode
   always_comb begin
      step = $signed({1'b0, move_step_ff});
      dx   = (held_keys_ff[HK_D] ? step : 8'sd0) - (held_keys_ff[HK_A] ? step : 8'sd0);
      dy   = (held_keys_ff[HK_S] ? step : 8'sd0) - (held_keys_ff[HK_W] ? step : 8'sd0);
      mv   = active_mode_ff && ((dx != 8'sd0) || (dy != 8'sd0));
      // inactive: only release what is still down
      lv   = active_mode_ff ? (held_keys_ff[HK_Q] != left_held_ff) : left_held_ff;
      rv   = active_mode_ff ? (held_keys_ff[HK_E] != right_held_ff) : right_held_ff;
   end

   always_comb begin
      held_keys_in     = held_keys_ff;
      alt_held_in      = alt_held_ff;
      last_alt_time_in = last_alt_time_ff;
      alt_seen_in      = alt_seen_ff;
      active_mode_in   = active_mode_ff;
      left_held_in     = left_held_ff;
      right_held_in    = right_held_ff;
      if (fire_i) begin
         if (is_key) begin
            active_mode_in = mode_key;
            if (alt_press) begin
               alt_held_in      = 1'b1;
               last_alt_time_in = item_i.time_ms;
               alt_seen_in      = 1'b1;
            end
            if (is_alt && !item_i.key_down) begin
               alt_held_in = 1'b0;
            end
            if (mode_key && mapped) begin
               held_keys_in = item_i.key_down ? (held_keys_ff | mask)
                                              : (held_keys_ff & ~mask);
            end
         end else begin
            if (lv) begin
               left_held_in = active_mode_ff && held_keys_ff[HK_Q];
            end
            if (rv) begin
               right_held_in = active_mode_ff && held_keys_ff[HK_E];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_keys_ff     <= '0;
         alt_held_ff      <= 1'b0;
         last_alt_time_ff <= '0;
         alt_seen_ff      <= 1'b0;
         active_mode_ff   <= 1'b0;
         left_held_ff     <= 1'b0;
         right_held_ff    <= 1'b0;
      end else begin
         held_keys_ff     <= held_keys_in;
         alt_held_ff      <= alt_held_in;
         last_alt_time_ff <= last_alt_time_in;
         alt_seen_ff      <= alt_seen_in;
         active_mode_ff   <= active_mode_in;
         left_held_ff     <= left_held_in;
         right_held_ff    <= right_held_in;
      end
   end

   // result candidates
   always_comb begin
      key_r           = '0;
      key_r.event_res = RES_KEY;
      key_r.consumed  = mode_key && mapped;
      key_r.mode_on   = mode_key;

      move_r           = '0;
      move_r.event_res = RES_MOVE;
      move_r.move_x    = dx;
      move_r.move_y    = dy;
      move_r.mode_on   = active_mode_ff;

      left_r           = '0;
      left_r.event_res = (active_mode_ff && held_keys_ff[HK_Q]) ? RES_LDOWN : RES_LUP;
      left_r.mode_on   = active_mode_ff;

      right_r           = '0;
      right_r.event_res = (active_mode_ff && held_keys_ff[HK_E]) ? RES_RDOWN : RES_RUP;
      right_r.mode_on   = active_mode_ff;
   end

   // pack the present results to the front, mark the final one
   always_comb begin
      if (is_key) begin
         count  = 2'd1;
         res[0] = key_r;
         res[1] = key_r;
         res[2] = key_r;
      end else begin
         count  = {1'b0, mv} + {1'b0, lv} + {1'b0, rv};
         res[0] = mv ? move_r : (lv ? left_r : right_r);
         res[1] = (mv && lv) ? left_r : right_r;
         res[2] = right_r;
      end
      for (int i = 0; i < RSP_SLOTS; i++) begin
         res[i].last = (count == 2'(i + 1));
      end
   end

   assign res_o   = res;
   assign count_o = count;

endmodule

/* rtl/kpt_rsp_queue.sv */
`include "key_to_pointer_translator_assert.svh"

module kpt_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_i,
   input  kpt_pkg::rsp_type [2:0] res_i,
   input  logic [1:0]             count_i,
   output logic                   ready_o,
   output kpt_pkg::rsp_type       rsp_o,
   output logic                   rsp_valid_o,
   input  logic                   rsp_ready_i
);
   import kpt_pkg::*;

   rsp_type [2:0] slot_ff;
   logic [1:0]    cnt_ff;
   logic          pop;

   assign pop         = rsp_valid_o && rsp_ready_i;
   assign rsp_valid_o = (cnt_ff != 2'd0);
   assign rsp_o       = slot_ff[0];
   // a new set may land as the final result of the previous one leaves
   assign ready_o     = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load_i) begin
         cnt_ff <= count_i;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         slot_ff <= res_i;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   `KPT_ASSERT_NOW(a_load_when_free, load_i, ready_o)
   `KPT_ASSERT_NOW(a_single_is_last, cnt_ff == 2'd1, slot_ff[0].last)
   `KPT_ASSERT_NOW(a_head_not_last, cnt_ff == 2'd2 || cnt_ff == 2'd3, !slot_ff[0].last)
   `KPT_ASSERT_NEXT(a_drain_step, pop && !load_i, cnt_ff == $past(cnt_ff) - 2'd1)

endmodule

/* rtl/key_to_pointer_translator.sv */
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  kind, key_code, key_down, time_ms
// rsp_      out        rsp_valid/rsp_ready  event_res, consumed, move_x, move_y, mode_on, last
// csr_      in         csr_write_en         csr_index, csr_wdata
//
// an item waits in the input register until the output queue is ready, then is decoded and
// its results load the output queue in the same edge; key events run at one per cycle while
// rsp_ready stays high; a poll tick's results (up to 3) leave the single-read output queue
// one by one, the next item held in the input register until the last is taken; a tick
// with no results holds nothing up; synchronous reset clears the control state and loads
// move_step 5, tap_window_ms 300; a stalled rsp_ready backs up to req_ready

module key_to_pointer_translator (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [7:0]        req_key_code,
   input  logic              req_key_down,
   input  logic [31:0]       req_time_ms,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_res,
   output logic              rsp_consumed,
   output logic signed [7:0] rsp_move_x,
   output logic signed [7:0] rsp_move_y,
   output logic              rsp_mode_on,
   output logic              rsp_last,

   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);
   import kpt_pkg::*;

   req_type         item_ff;
   logic            item_valid_ff, item_valid_in;
   logic            req_xfer;
   logic            fire;
   logic            q_ready;
   rsp_type [2:0]   res;
   logic [1:0]      count;
   rsp_type         rsp;

   assign req_xfer      = req_valid && req_ready;
   assign fire          = item_valid_ff && q_ready;
   assign req_ready     = !item_valid_ff || fire;
   assign item_valid_in = req_xfer || (item_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.kind     <= req_kind;
         item_ff.key_code <= req_key_code;
         item_ff.key_down <= req_key_down;
         item_ff.time_ms  <= req_time_ms;
      end
   end

   kpt_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire_i       (fire),
      .item_i       (item_ff),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .res_o        (res),
      .count_o      (count)
   );

   kpt_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .load_i      (fire),
      .res_i       (res),
      .count_i     (count),
      .ready_o     (q_ready),
      .rsp_o       (rsp),
      .rsp_valid_o (rsp_valid),
      .rsp_ready_i (rsp_ready)
   );

   assign rsp_event_res = rsp.event_res;
   assign rsp_consumed  = rsp.consumed;
   assign rsp_move_x    = rsp.move_x;
   assign rsp_move_y    = rsp.move_y;
   assign rsp_mode_on   = rsp.mode_on;
   assign rsp_last      = rsp.last;

endmodule
